/* rtl/bdli_pkg.sv */
// Package for the brace depth line indenter.
// Holds character codes, lexical modes, line kinds, the scan flag struct and defaults.
// No dependencies.
package bdli_pkg;

  localparam int unsigned CHAR_W = 16;
  localparam int unsigned TAB_W  = 5;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned LVL_W  = 8;
  localparam int unsigned COL_W  = 12;

  localparam int unsigned MAX_DEPTH_DEF       = 255;
  localparam int unsigned MAX_LINE_BRACES_DEF = 4095;

  localparam logic [TAB_W-1:0] TAB_RESET = 5'd4;
  localparam logic [TAB_W-1:0] TAB_MIN   = 5'd1;
  localparam logic [TAB_W-1:0] TAB_MAX   = 5'd16;

  localparam logic [CHAR_W-1:0] CH_NL      = 16'd10;
  localparam logic [CHAR_W-1:0] CH_TAB     = 16'd9;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 16'd32;
  localparam logic [CHAR_W-1:0] CH_LBRACE  = 16'd123;
  localparam logic [CHAR_W-1:0] CH_RBRACE  = 16'd125;
  localparam logic [CHAR_W-1:0] CH_HASH    = 16'd35;
  localparam logic [CHAR_W-1:0] CH_DQUOTE  = 16'd34;
  localparam logic [CHAR_W-1:0] CH_SQUOTE  = 16'd39;
  localparam logic [CHAR_W-1:0] CH_SLASH   = 16'd47;
  localparam logic [CHAR_W-1:0] CH_STAR    = 16'd42;
  localparam logic [CHAR_W-1:0] CH_BSLASH  = 16'd92;

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_BLOCK  = 2'd1;
  localparam logic [1:0] MODE_STRING = 2'd2;
  localparam logic [1:0] MODE_CHAR   = 2'd3;

  localparam logic [KIND_W-1:0] KIND_BLANK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DROPPED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PREPROC = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CODE    = 2'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic       escape;
    logic       slash;
    logic       star;
    logic       rest_comment;
  } scan_state_t;

  function automatic logic [TAB_W-1:0] clamp_tab(input logic [TAB_W-1:0] v);
    logic [TAB_W-1:0] r;
    r = v;
    if (v < TAB_MIN) r = TAB_MIN;
    if (v > TAB_MAX) r = TAB_MAX;
    return r;
  endfunction

endpackage

/* rtl/bdli_scan.sv */
// Lexical scanner step for one character of a line.
// Computes the next comment and literal flags and flags brace hits. Uses bdli_pkg.
module bdli_scan
  import bdli_pkg::*;
(
  input  logic [CHAR_W-1:0] char_code,
  input  scan_state_t       st,
  output scan_state_t       st_nxt,
  output logic              open_hit,
  output logic              close_hit
);

  logic             taken;
  logic [CHAR_W-1:0] quote;

  always_comb begin
    st_nxt    = st;
    open_hit  = 1'b0;
    close_hit = 1'b0;
    taken     = 1'b0;
    quote     = (st.mode == MODE_STRING) ? CH_DQUOTE : CH_SQUOTE;
    if (!st.rest_comment) begin
      unique case (st.mode) inside
        MODE_BLOCK: begin
          if (st.star && char_code == CH_SLASH) begin
            st_nxt.mode = MODE_NORMAL;
            st_nxt.star = 1'b0;
          end else begin
            st_nxt.star = (char_code == CH_STAR);
          end
        end
        MODE_STRING, MODE_CHAR: begin
          if (st.escape) begin
            st_nxt.escape = 1'b0;
          end else if (char_code == CH_BSLASH) begin
            st_nxt.escape = 1'b1;
          end else if (char_code == quote) begin
            st_nxt.mode = MODE_NORMAL;
          end
        end
        default: begin
          if (st.slash) begin
            st_nxt.slash = 1'b0;
            if (char_code == CH_SLASH) begin
              st_nxt.rest_comment = 1'b1;
              taken = 1'b1;
            end else if (char_code == CH_STAR) begin
              st_nxt.mode = MODE_BLOCK;
              st_nxt.star = 1'b0;
              taken = 1'b1;
            end
          end
          if (!taken) begin
            if (char_code == CH_SLASH) begin
              st_nxt.slash = 1'b1;
            end else if (char_code == CH_DQUOTE) begin
              st_nxt.mode   = MODE_STRING;
              st_nxt.escape = 1'b0;
            end else if (char_code == CH_SQUOTE) begin
              st_nxt.mode   = MODE_CHAR;
              st_nxt.escape = 1'b0;
            end else if (char_code == CH_LBRACE) begin
              open_hit = 1'b1;
            end else if (char_code == CH_RBRACE) begin
              close_hit = 1'b1;
            end
          end
        end
      endcase
    end
  end

endmodule

/* rtl/brace_depth_line_indenter.sv */
// Top level of the brace depth line indenter.
// Holds the input register, line state, brace counters and result register.
// Uses bdli_pkg and bdli_scan.
//
// Usage: characters of source text enter on in_char_code with in_valid/in_stall.
// A transaction is accepted at a rising edge with in_valid high and in_stall low.
// Each newline character produces one result transaction on the out_ channel
// (line kind, indent level, indent columns, depth after the line); other
// characters produce none. The tab size register is written through cfg_wr_en
// and cfg_tab_size; the user must write it only while the block is idle (not
// enforced by the block); values are clamped to 1..16. A newline passes through
// the input register and then the result register to out_valid, the only stages.
// One character per cycle is taken unless a stalled result holds a newline. When
// the receiver stalls, the result holds and a following newline waits in the
// input register; other characters keep flowing until a second newline is
// reached, then in_stall rises. Synchronous active-low reset clears the scan
// state, depth, tab size (to 4) and both valid flags.
module brace_depth_line_indenter
  import bdli_pkg::*;
#(
  parameter int unsigned MAX_DEPTH       = MAX_DEPTH_DEF,
  parameter int unsigned MAX_LINE_BRACES = MAX_LINE_BRACES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAR_W-1:0] in_char_code,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [KIND_W-1:0] out_line_kind,
  output logic [LVL_W-1:0]  out_indent_level,
  output logic [COL_W-1:0]  out_indent_columns,
  output logic [LVL_W-1:0]  out_depth_after,
  input  logic              cfg_wr_en,
  input  logic [TAB_W-1:0]  cfg_tab_size
);

  localparam int unsigned DEPTH_W = $clog2(MAX_DEPTH + 1);
  localparam int unsigned BR_W    = $clog2(MAX_LINE_BRACES + 1);
  localparam int unsigned EXT_W   = (DEPTH_W > LVL_W) ? DEPTH_W : LVL_W;
  localparam int unsigned SUM_W   = ((DEPTH_W > BR_W) ? DEPTH_W : BR_W) + 2;
  localparam int unsigned PROD_W  = LVL_W + TAB_W;

  logic              in_v_r;
  logic [CHAR_W-1:0] char_r;
  logic [TAB_W-1:0]  tab_r;

  scan_state_t       scan_r, scan_nxt, scan_step;
  logic              has_content_r, has_content_nxt;
  logic              preproc_r, preproc_nxt;
  logic              starts_close_r, starts_close_nxt;
  logic              prev_blank_r, prev_blank_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [BR_W-1:0]   open_r, open_nxt;
  logic [BR_W-1:0]   close_r, close_nxt;

  logic              out_v_r;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [LVL_W-1:0]  level_r, level_nxt;
  logic [COL_W-1:0]  cols_r, cols_nxt;
  logic [LVL_W-1:0]  dafter_r, dafter_nxt;

  logic              is_nl, is_blank, do_scan, open_hit, close_hit;
  logic              out_free, process;
  logic [EXT_W-1:0]  level_ext, depth_ext;
  logic signed [SUM_W-1:0] depth_sum;
  logic [PROD_W-1:0] prod;

  bdli_scan u_scan (
    .char_code (char_r),
    .st        (scan_r),
    .st_nxt    (scan_step),
    .open_hit  (open_hit),
    .close_hit (close_hit)
  );

  assign is_nl    = (char_r == CH_NL);
  assign is_blank = (char_r == CH_SPACE) || (char_r == CH_TAB);
  assign out_free = !out_v_r || !out_stall;
  assign process  = in_v_r && (!is_nl || out_free);
  assign in_stall = in_v_r && !process;

  assign depth_sum = $signed(SUM_W'(depth_r)) + $signed(SUM_W'(open_r))
                   - $signed(SUM_W'(close_r));
  assign depth_ext = EXT_W'(depth_r);

  always_comb begin
    scan_nxt         = scan_r;
    has_content_nxt  = has_content_r;
    preproc_nxt      = preproc_r;
    starts_close_nxt = starts_close_r;
    prev_blank_nxt   = prev_blank_r;
    depth_nxt        = depth_r;
    open_nxt         = open_r;
    close_nxt        = close_r;
    do_scan          = 1'b0;
    kind_nxt         = KIND_CODE;
    level_ext        = '0;
    if (is_nl) begin
      if (!has_content_r) begin
        kind_nxt       = prev_blank_r ? KIND_DROPPED : KIND_BLANK;
        prev_blank_nxt = 1'b1;
      end else if (preproc_r) begin
        kind_nxt       = KIND_PREPROC;
        prev_blank_nxt = 1'b0;
      end else begin
        kind_nxt       = KIND_CODE;
        prev_blank_nxt = 1'b0;
        level_ext      = depth_ext;
        if (starts_close_r && depth_r != '0) begin
          level_ext = EXT_W'(depth_r - 1'b1);
        end
        if (depth_sum[SUM_W-1]) begin
          depth_nxt = '0;
        end else if (depth_sum > SUM_W'(MAX_DEPTH)) begin
          depth_nxt = DEPTH_W'(MAX_DEPTH);
        end else begin
          depth_nxt = depth_sum[DEPTH_W-1:0];
        end
      end
      scan_nxt.slash        = 1'b0;
      scan_nxt.star         = 1'b0;
      scan_nxt.rest_comment = 1'b0;
      has_content_nxt       = 1'b0;
      preproc_nxt           = 1'b0;
      starts_close_nxt      = 1'b0;
      open_nxt              = '0;
      close_nxt             = '0;
    end else if (!has_content_r) begin
      if (!is_blank) begin
        has_content_nxt = 1'b1;
        if (char_r == CH_HASH) begin
          preproc_nxt = 1'b1;
        end else begin
          starts_close_nxt = (char_r == CH_RBRACE);
          do_scan          = 1'b1;
        end
      end
    end else if (!preproc_r) begin
      do_scan = 1'b1;
    end
    if (do_scan) begin
      scan_nxt = scan_step;
      if (open_hit && open_r < BR_W'(MAX_LINE_BRACES)) begin
        open_nxt = open_r + 1'b1;
      end
      if (close_hit && close_r < BR_W'(MAX_LINE_BRACES)) begin
        close_nxt = close_r + 1'b1;
      end
    end
    level_nxt  = (level_ext > EXT_W'(8'hFF)) ? 8'hFF : level_ext[LVL_W-1:0];
    prod       = PROD_W'(level_nxt) * PROD_W'(tab_r);
    cols_nxt   = prod[COL_W-1:0];
    dafter_nxt = (EXT_W'(depth_nxt) > EXT_W'(8'hFF)) ? 8'hFF
               : LVL_W'(EXT_W'(depth_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r         <= 1'b0;
      tab_r          <= TAB_RESET;
      scan_r         <= '0;
      has_content_r  <= 1'b0;
      preproc_r      <= 1'b0;
      starts_close_r <= 1'b0;
      prev_blank_r   <= 1'b0;
      depth_r        <= '0;
      open_r         <= '0;
      close_r        <= '0;
      out_v_r        <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        tab_r <= clamp_tab(cfg_tab_size);
      end
      if (!in_stall) begin
        in_v_r <= in_valid;
      end
      if (process) begin
        scan_r         <= scan_nxt;
        has_content_r  <= has_content_nxt;
        preproc_r      <= preproc_nxt;
        starts_close_r <= starts_close_nxt;
        prev_blank_r   <= prev_blank_nxt;
        depth_r        <= depth_nxt;
        open_r         <= open_nxt;
        close_r        <= close_nxt;
      end
      if (process && is_nl) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      char_r <= in_char_code;
    end
    if (process && is_nl) begin
      kind_r   <= kind_nxt;
      level_r  <= level_nxt;
      cols_r   <= cols_nxt;
      dafter_r <= dafter_nxt;
    end
  end

  assign out_valid          = out_v_r;
  assign out_line_kind      = kind_r;
  assign out_indent_level   = level_r;
  assign out_indent_columns = cols_r;
  assign out_depth_after    = dafter_r;

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    EXT_W'(depth_r) <= EXT_W'(MAX_DEPTH))
    else $error("brace depth above its limit");

  a_no_indent_off_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && kind_r != KIND_CODE |-> level_r == '0 && cols_r == '0)
    else $error("indent given on a line that is not code");

  a_reset_clears_out: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_v_r && !in_v_r)
    else $error("valid flag set right after reset");

endmodule
